FILE: hdl/pds_pkg.sv
// Shared constants, types and command codes for the PLL divider search block.
`default_nettype none
package pds_pkg;

  localparam int FREQ_FRAC_BITS = 24;

  localparam int FREQ_W = 32;
  localparam int VCO_W  = 40;                // target * P, P up to 127
  localparam int MV_W   = VCO_W + 9;         // vco * M
  localparam int REM_W  = MV_W + 2;          // 2*mv + ref
  localparam int DSR_W  = FREQ_W + 1;        // 2*ref
  localparam int MB_W   = 25;                // multiplier b operand width
  localparam int PROD_W = FREQ_W + MB_W;
  localparam int XP_W   = PROD_W + MB_W;     // cross product width
  localparam int NUM_W  = 32;

  // Register indexes on the configuration channel
  localparam logic [2:0] CFG_VCO_MIN = 3'd0;
  localparam logic [2:0] CFG_VCO_MAX = 3'd1;
  localparam logic [2:0] CFG_MAX_M   = 3'd2;
  localparam logic [2:0] CFG_MAX_N   = 3'd3;
  localparam logic [2:0] CFG_MAX_P   = 3'd4;

  // Datapath operations
  localparam logic [4:0] OP_NONE   = 5'd0;
  localparam logic [4:0] OP_START  = 5'd1;
  localparam logic [4:0] OP_PNEXT  = 5'd2;
  localparam logic [4:0] OP_MINIT  = 5'd3;
  localparam logic [4:0] OP_DLOAD  = 5'd4;
  localparam logic [4:0] OP_DSTEP  = 5'd5;
  localparam logic [4:0] OP_MNR    = 5'd6;
  localparam logic [4:0] OP_NUM    = 5'd7;
  localparam logic [4:0] OP_LLO    = 5'd8;
  localparam logic [4:0] OP_LHI    = 5'd9;
  localparam logic [4:0] OP_RLO    = 5'd10;
  localparam logic [4:0] OP_RHI    = 5'd11;
  localparam logic [4:0] OP_RADD   = 5'd12;
  localparam logic [4:0] OP_DECIDE = 5'd13;
  localparam logic [4:0] OP_MNEXT  = 5'd14;
  localparam logic [4:0] OP_PLOAD  = 5'd15;
  localparam logic [4:0] OP_OUT    = 5'd16;

  typedef struct packed {
    logic [7:0]  vco_min;
    logic [7:0]  vco_max;
    logic [8:0]  max_m;
    logic [11:0] max_n;
    logic [6:0]  max_p;
  } cfg_t;

  typedef struct packed {
    logic [4:0] op;
  } cmd_t;

  typedef struct packed {
    logic p_stop;
    logic p_skip;
    logic m_stop;
    logic div_ovf;
    logic k_zero;
    logic n_over;
    logic found;
  } stat_t;

endpackage
`default_nettype wire

FILE: hdl/pds_ctrl.sv
// Sequencer for the P / M search loops, the quotient pass and the result strobe.
`default_nettype none
module pds_ctrl import pds_pkg::*; (
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   start_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  busy_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PCHK = 4'd1;
  localparam logic [3:0] S_MCHK = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_NCHK = 4'd4;
  localparam logic [3:0] S_NUM  = 4'd5;
  localparam logic [3:0] S_LLO  = 4'd6;
  localparam logic [3:0] S_LHI  = 4'd7;
  localparam logic [3:0] S_RLO  = 4'd8;
  localparam logic [3:0] S_RHI  = 4'd9;
  localparam logic [3:0] S_RADD = 4'd10;
  localparam logic [3:0] S_DEC  = 4'd11;
  localparam logic [3:0] S_MNX  = 4'd12;
  localparam logic [3:0] S_PDIV = 4'd13;
  localparam logic [3:0] S_FIN  = 4'd14;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o.op = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.op = OP_START;
          state_d = S_PCHK;
        end
      end
      S_PCHK: begin
        if (stat_i.p_stop) begin
          if (stat_i.found) begin
            cmd_o.op = OP_PLOAD;
            state_d = S_PDIV;
          end else begin
            cmd_o.op = OP_OUT;
            state_d = S_IDLE;
          end
        end else if (stat_i.p_skip) begin
          cmd_o.op = OP_PNEXT;
        end else begin
          cmd_o.op = OP_MINIT;
          state_d = S_MCHK;
        end
      end
      S_MCHK: begin
        if (stat_i.m_stop) begin
          cmd_o.op = OP_PNEXT;
          state_d = S_PCHK;
        end else begin
          cmd_o.op = OP_DLOAD;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (stat_i.div_ovf) begin
          cmd_o.op = OP_PNEXT;
          state_d = S_PCHK;
        end else begin
          cmd_o.op = OP_DSTEP;
          if (stat_i.k_zero) state_d = S_NCHK;
        end
      end
      S_NCHK: begin
        if (stat_i.n_over) begin
          cmd_o.op = OP_PNEXT;
          state_d = S_PCHK;
        end else begin
          cmd_o.op = OP_MNR;
          state_d = S_NUM;
        end
      end
      S_NUM: begin
        cmd_o.op = OP_NUM;
        state_d = S_LLO;
      end
      S_LLO: begin
        cmd_o.op = OP_LLO;
        state_d = S_LHI;
      end
      S_LHI: begin
        cmd_o.op = OP_LHI;
        state_d = S_RLO;
      end
      S_RLO: begin
        cmd_o.op = OP_RLO;
        state_d = S_RHI;
      end
      S_RHI: begin
        cmd_o.op = OP_RHI;
        state_d = S_RADD;
      end
      S_RADD: begin
        cmd_o.op = OP_RADD;
        state_d = S_DEC;
      end
      S_DEC: begin
        cmd_o.op = OP_DECIDE;
        state_d = S_MNX;
      end
      S_MNX: begin
        cmd_o.op = OP_MNEXT;
        state_d = S_MCHK;
      end
      S_PDIV: begin
        cmd_o.op = OP_DSTEP;
        if (stat_i.k_zero) state_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.op = OP_OUT;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule
`default_nettype wire

FILE: hdl/pds_dp.sv
// Search datapath: loop counters, shared divider, shared multiplier, best setting, result.
`default_nettype none
module pds_dp import pds_pkg::*; (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  cmd_t              cmd_i,
  input  cfg_t              cfg_i,
  input  wire  [FREQ_W-1:0] ref_freq_i,
  input  wire  [FREQ_W-1:0] target_freq_i,
  output stat_t             stat_o,
  output logic              done_o,
  output logic [63:0]       reg_word_o,
  output logic [11:0]       mult_n_o,
  output logic [8:0]        div_m_o,
  output logic [6:0]        post_div_o,
  output logic [2:0]        shift_np_o,
  output logic [5:0]        quot_q_o,
  output logic [8:0]        rem_r_o,
  output logic [1:0]        vco_band_o,
  output logic              found_o
);

  localparam logic [VCO_W-1:0] BAND1 = VCO_W'(125) << FREQ_FRAC_BITS;
  localparam logic [VCO_W-1:0] BAND2 = VCO_W'(150) << FREQ_FRAC_BITS;
  localparam logic [VCO_W-1:0] BAND3 = VCO_W'(175) << FREQ_FRAC_BITS;
  localparam logic [3:0]       K_NCHK = 4'd12;
  localparam logic [3:0]       K_POST = 4'd15;

  logic [FREQ_W-1:0] ref_q, tgt_q;
  logic [7:0]        p_q;
  logic [VCO_W-1:0]  vco_q;
  logic [9:0]        m_q;
  logic [MV_W-1:0]   mv_q;
  logic [REM_W-1:0]  rem_q;
  logic [DSR_W-1:0]  dsr_q;
  logic [15:0]       quo_q;
  logic [3:0]        k_q;
  logic [PROD_W-1:0] prod_q;
  logic [NUM_W-1:0]  num_q;
  logic [XP_W-1:0]   lhs_q, rhs_q;
  logic [NUM_W-1:0]  bnum_q;
  logic [MV_W-1:0]   bden_q;
  logic [11:0]       bn_q;
  logic [8:0]        bm_q;
  logic [6:0]        bp_q;
  logic [VCO_W-1:0]  bvco_q;
  logic              found_q;
  logic [2:0]        np_q;
  logic              done_q;

  // shared multiplier
  logic [FREQ_W-1:0] mul_a;
  logic [MB_W-1:0]   mul_b;
  logic [PROD_W-1:0] mul_p;

  always_comb begin
    mul_a = num_q;
    mul_b = bden_q[MB_W-1:0];
    case (cmd_i.op)
      OP_MNR: begin
        mul_a = ref_q;
        mul_b = MB_W'(quo_q[11:0]);
      end
      OP_LHI: begin
        mul_b = MB_W'(bden_q[MV_W-1:MB_W]);
      end
      OP_RLO: begin
        mul_a = bnum_q;
        mul_b = mv_q[MB_W-1:0];
      end
      OP_RHI: begin
        mul_a = bnum_q;
        mul_b = MB_W'(mv_q[MV_W-1:MB_W]);
      end
      default: ;
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // shared restoring divider step
  logic [REM_W-1:0] rem_sh, dsr_sh;
  logic             div_bit;
  assign rem_sh  = rem_q >> k_q;
  assign div_bit = rem_sh >= REM_W'(dsr_q);
  assign dsr_sh  = REM_W'(dsr_q) << k_q;

  // n*ref, the product for the error numerator |n*ref - mv|
  logic [MV_W-1:0] nr;
  assign nr = MV_W'(prod_q);

  // shift np: one less for each doubling of M that N reaches
  logic [12:0] n13, m13;
  logic [2:0]  np_cnt;
  assign n13 = 13'(bn_q);
  assign m13 = 13'(bm_q);
  assign np_cnt = 3'(n13 >= (m13 << 1)) + 3'(n13 >= (m13 << 2))
                + 3'(n13 >= (m13 << 3)) + 3'(n13 >= (m13 << 4));

  logic [1:0] band;
  always_comb begin
    if (bvco_q < BAND1)      band = 2'd0;
    else if (bvco_q < BAND2) band = 2'd1;
    else if (bvco_q < BAND3) band = 2'd2;
    else                     band = 2'd3;
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_START: begin
        ref_q <= ref_freq_i;
        tgt_q <= target_freq_i;
        p_q   <= 8'd1;
        vco_q <= VCO_W'(target_freq_i);
      end
      OP_PNEXT: begin
        p_q   <= p_q + 8'd1;
        vco_q <= vco_q + VCO_W'(tgt_q);
      end
      OP_MINIT: begin
        m_q  <= 10'd1;
        mv_q <= MV_W'(vco_q);
      end
      OP_MNEXT: begin
        m_q  <= m_q + 10'd1;
        mv_q <= mv_q + MV_W'(vco_q);
      end
      OP_DLOAD: begin
        rem_q <= REM_W'({mv_q, 1'b0}) + REM_W'(ref_q);
        dsr_q <= {ref_q, 1'b0};
        quo_q <= '0;
        k_q   <= K_NCHK;
      end
      OP_PLOAD: begin
        np_q  <= 3'd4 - np_cnt;
        rem_q <= REM_W'(16'(bn_q) << (3'd4 - np_cnt));
        dsr_q <= DSR_W'(bm_q);
        quo_q <= '0;
        k_q   <= K_POST;
      end
      OP_DSTEP: begin
        quo_q <= {quo_q[14:0], div_bit};
        if (div_bit) rem_q <= rem_q - dsr_sh;
        k_q <= k_q - 4'd1;
      end
      OP_MNR: begin
        prod_q <= mul_p;
      end
      OP_NUM: begin
        num_q <= (nr > mv_q) ? NUM_W'(nr - mv_q) : NUM_W'(mv_q - nr);
      end
      OP_LLO: begin
        prod_q <= mul_p;
      end
      OP_LHI: begin
        lhs_q  <= XP_W'(prod_q);
        prod_q <= mul_p;
      end
      OP_RLO: begin
        lhs_q  <= lhs_q + (XP_W'(prod_q) << MB_W);
        prod_q <= mul_p;
      end
      OP_RHI: begin
        rhs_q  <= XP_W'(prod_q);
        prod_q <= mul_p;
      end
      OP_RADD: begin
        rhs_q <= rhs_q + (XP_W'(prod_q) << MB_W);
      end
      OP_DECIDE: begin
        if (!found_q || (lhs_q < rhs_q)) begin
          bnum_q <= num_q;
          bden_q <= mv_q;
          bn_q   <= quo_q[11:0];
          bm_q   <= m_q[8:0];
          bp_q   <= p_q[6:0];
          bvco_q <= vco_q;
        end
      end
      OP_OUT: begin
        if (found_q) begin
          reg_word_o <= {8'h57, 8'h00, {1'b0, bp_q}, {1'b0, bp_q}, bn_q[11:4],
                         bn_q[3:0], rem_q[8:5], rem_q[4:0], quo_q[5:3],
                         quo_q[2:0], np_q[2:0], band};
          mult_n_o   <= bn_q;
          div_m_o    <= bm_q;
          post_div_o <= bp_q;
          shift_np_o <= np_q;
          quot_q_o   <= quo_q[5:0];
          rem_r_o    <= rem_q[8:0];
          vco_band_o <= band;
        end else begin
          reg_word_o <= '0;
          mult_n_o   <= '0;
          div_m_o    <= '0;
          post_div_o <= '0;
          shift_np_o <= '0;
          quot_q_o   <= '0;
          rem_r_o    <= '0;
          vco_band_o <= '0;
        end
      end
      default: ;
    endcase
  end

  // control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      found_o <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= (cmd_i.op == OP_OUT);
      if (cmd_i.op == OP_START) found_q <= 1'b0;
      else if (cmd_i.op == OP_DECIDE) found_q <= 1'b1;
      if (cmd_i.op == OP_OUT) found_o <= found_q;
    end
  end

  assign done_o = done_q;

  assign stat_o.p_stop  = (ref_q == '0) || (tgt_q == '0) || (p_q > {1'b0, cfg_i.max_p})
                        || (vco_q > (VCO_W'(cfg_i.vco_max) << FREQ_FRAC_BITS));
  assign stat_o.p_skip  = vco_q < (VCO_W'(cfg_i.vco_min) << FREQ_FRAC_BITS);
  assign stat_o.m_stop  = m_q > {1'b0, cfg_i.max_m};
  assign stat_o.div_ovf = (k_q == K_NCHK) && div_bit;
  assign stat_o.k_zero  = (k_q == 4'd0);
  assign stat_o.n_over  = quo_q > {4'd0, cfg_i.max_n};
  assign stat_o.found   = found_q;

endmodule
`default_nettype wire

FILE: hdl/pll_divider_search.sv
// Top level of the PLL N / M / P divider search: configuration registers and the two halves.
`default_nettype none
// Usage:
//   Drive ref_freq_i / target_freq_i (MHz, unsigned, 24 fraction bits) and raise
//   start_i; the transfer happens at an edge with start_i high and busy_o low.
//   One result per transfer, marked by done_o for a single cycle; the receiver
//   cannot stall, fields hold until the next result. found_o low: no setting,
//   all fields zero. Config: cfg_valid_i with cfg_index_i / cfg_data_i,
//   cfg_ready_o tied high, write only while idle, unknown indexes ignored.
// Sequence:
//   One shared restoring divider and one 32x25 multiplier, stepped by the
//   controller. A P below the VCO window is skipped. An M trial is the divider
//   load, the divider steps for N, n*ref, the error, the exact compare, the
//   best update and the M advance. A P in the window first sets up its M loop,
//   which ends when M runs out, on N above 12 bits or on N above max N; each
//   of these moves on to the next P. The finish is the load, the quotient
//   steps and the output, or only the output with no setting; done_o rises
//   in the cycle after the output. A new start is taken while done_o is up.
// Reset:
//   rst_ni is asynchronous, active low; the controller goes idle and the
//   registers take 80, 201, 511, 4095, 127.
module pll_divider_search import pds_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  output logic        busy_o,
  input  wire  [31:0] ref_freq_i,
  input  wire  [31:0] target_freq_i,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [2:0]  cfg_index_i,
  input  wire  [11:0] cfg_data_i,
  output logic        done_o,
  output logic [63:0] reg_word_o,
  output logic [11:0] mult_n_o,
  output logic [8:0]  div_m_o,
  output logic [6:0]  post_div_o,
  output logic [2:0]  shift_np_o,
  output logic [5:0]  quot_q_o,
  output logic [8:0]  rem_r_o,
  output logic [1:0]  vco_band_o,
  output logic        found_o
);

  cfg_t  cfg_q;
  cmd_t  cmd;
  stat_t stat;
  logic  busy;

  assign cfg_ready_o = 1'b1;

  // configuration register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vco_min <= 8'd80;
      cfg_q.vco_max <= 8'd201;
      cfg_q.max_m   <= 9'd511;
      cfg_q.max_n   <= 12'd4095;
      cfg_q.max_p   <= 7'd127;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_VCO_MIN: cfg_q.vco_min <= cfg_data_i[7:0];
        CFG_VCO_MAX: cfg_q.vco_max <= cfg_data_i[7:0];
        CFG_MAX_M:   cfg_q.max_m   <= cfg_data_i[8:0];
        CFG_MAX_N:   cfg_q.max_n   <= cfg_data_i[11:0];
        CFG_MAX_P:   cfg_q.max_p   <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  pds_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  pds_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_i         (cfg_q),
    .ref_freq_i    (ref_freq_i),
    .target_freq_i (target_freq_i),
    .stat_o        (stat),
    .done_o        (done_o),
    .reg_word_o    (reg_word_o),
    .mult_n_o      (mult_n_o),
    .div_m_o       (div_m_o),
    .post_div_o    (post_div_o),
    .shift_np_o    (shift_np_o),
    .quot_q_o      (quot_q_o),
    .rem_r_o       (rem_r_o),
    .vco_band_o    (vco_band_o),
    .found_o       (found_o)
  );

  assign busy_o = busy;

endmodule
`default_nettype wire
